### hw/rtl/c2s_pkg.sv
// Shared types, constants and helpers for the CAN frame to SLCAN ASCII encoder.
// No dependencies; imported by every module of the block.
package c2s_pkg;

  localparam int unsigned MaxPayloadDef = 64;
  localparam int unsigned QueueDepth    = 2;
  localparam int unsigned NibW          = 40;
  localparam int unsigned NibCntW       = 4;
  localparam int unsigned CharW         = 7;

  localparam logic [CharW-1:0] AsciiCr      = 7'h0D;
  localparam logic [CharW-1:0] LetterExtBrs = 7'h44;  // D
  localparam logic [CharW-1:0] LetterStdBrs = 7'h64;  // d
  localparam logic [CharW-1:0] LetterExtFd  = 7'h42;  // B
  localparam logic [CharW-1:0] LetterStdFd  = 7'h62;  // b
  localparam logic [CharW-1:0] LetterExtCls = 7'h54;  // T
  localparam logic [CharW-1:0] LetterStdCls = 7'h74;  // t

  typedef enum logic {
    OpHeader = 1'b0,
    OpData   = 1'b1
  } op_e;

  // One line fragment: optional letter, then hex nibbles MSB first, then optional CR.
  typedef struct packed {
    logic               has_letter;
    logic [CharW-1:0]   letter;
    logic [NibW-1:0]    nibs;
    logic [NibCntW-1:0] n_nib;
    logic               add_cr;
  } job_t;

  function automatic logic [CharW-1:0] hex_char(input logic [3:0] n);
    logic [CharW-1:0] c;
    if (n < 4'd10) c = 7'h30 + {3'b000, n};
    else           c = 7'h37 + {3'b000, n};
    return c;
  endfunction

  function automatic logic [3:0] length_code(input logic [6:0] len);
    logic [3:0] code;
    if (len <= 7'd8)       code = len[3:0];
    else if (len <= 7'd12) code = 4'h9;
    else if (len <= 7'd16) code = 4'hA;
    else if (len <= 7'd20) code = 4'hB;
    else if (len <= 7'd24) code = 4'hC;
    else if (len <= 7'd32) code = 4'hD;
    else if (len <= 7'd48) code = 4'hE;
    else                   code = 4'hF;
    return code;
  endfunction

endpackage

### hw/rtl/can_frame_to_slcan_ascii_top.sv
// CAN / CAN FD frame to SLCAN ASCII line encoder, top level.
// The first character of an item passes through the queue, the back-end job registers and the output register.
// The back end emits one character per cycle while the output is not stalled: a header is 5 to 11 characters,
// a data item 2 or 3; the front end takes one item per cycle while the 2-entry queue has room.
// Reset (rst_ni low, async): clears pending byte count, queue and output valid; no line is open.
// Depends on c2s_pkg, c2s_front, c2s_queue, c2s_back.
module can_frame_to_slcan_ascii_top #(
  parameter int unsigned MaxPayload = c2s_pkg::MaxPayloadDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic                      op_i,
  input  logic [28:0]               ident_i,
  input  logic                      is_extended_i,
  input  logic                      is_fd_i,
  input  logic                      bit_rate_switch_i,
  input  logic [6:0]                byte_count_i,
  input  logic [7:0]                data_byte_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [c2s_pkg::CharW-1:0] ascii_char_o,
  output logic                      end_of_line_o,
  output logic                      last_of_run_o
);
  import c2s_pkg::*;

  job_t push_job, head_job;
  logic push, pop, q_full, q_empty;

  // Front: classify each transfer, track open line, build a job for the queue.
  c2s_front #(
    .MaxPayload(MaxPayload)
  ) u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .op_i             (op_i),
    .ident_i          (ident_i),
    .is_extended_i    (is_extended_i),
    .is_fd_i          (is_fd_i),
    .bit_rate_switch_i(bit_rate_switch_i),
    .byte_count_i     (byte_count_i),
    .data_byte_i      (data_byte_i),
    .q_full_i         (q_full),
    .push_o           (push),
    .job_o            (push_job)
  );

  // Queue: decouple classification from character output so each side stalls alone.
  c2s_queue #(
    .Depth(QueueDepth)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .wdata_i(push_job),
    .pop_i  (pop),
    .rdata_o(head_job),
    .full_o (q_full),
    .empty_o(q_empty)
  );

  // Back: shift jobs out as characters through the output register.
  c2s_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .job_i        (head_job),
    .job_avail_i  (!q_empty),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .ascii_char_o (ascii_char_o),
    .end_of_line_o(end_of_line_o),
    .last_of_run_o(last_of_run_o)
  );

  // The closing CR is always the final character of its item.
  a_eol_is_cr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && end_of_line_o |-> last_of_run_o && ascii_char_o == AsciiCr)
    else $error("end of line without CR or last flag");

  // The front never pushes into a full queue.
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !q_full)
    else $error("job pushed into full queue");

  // A job is only taken from a non-empty queue.
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !q_empty)
    else $error("job popped from empty queue");

endmodule

### hw/rtl/c2s_front.sv
// Front end: accepts header and data items, tracks pending bytes, builds line jobs.
// Depends on c2s_pkg.
module c2s_front #(
  parameter int unsigned MaxPayload = c2s_pkg::MaxPayloadDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic          op_i,
  input  logic [28:0]   ident_i,
  input  logic          is_extended_i,
  input  logic          is_fd_i,
  input  logic          bit_rate_switch_i,
  input  logic [6:0]    byte_count_i,
  input  logic [7:0]    data_byte_i,
  input  logic          q_full_i,
  output logic          push_o,
  output c2s_pkg::job_t job_o
);
  import c2s_pkg::*;

  localparam int unsigned PendW = $clog2(MaxPayload + 1);

  logic [PendW-1:0] pending_q, pending_d;
  logic [6:0]       sat_len;
  logic [3:0]       dlc;
  logic [CharW-1:0] letter;
  logic             accept;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign sat_len    = (byte_count_i > 7'(MaxPayload)) ? 7'(MaxPayload) : byte_count_i;
  assign dlc        = length_code(sat_len);

  always_comb begin
    if (is_fd_i) begin
      if (bit_rate_switch_i) letter = is_extended_i ? LetterExtBrs : LetterStdBrs;
      else                   letter = is_extended_i ? LetterExtFd  : LetterStdFd;
    end else begin
      letter = is_extended_i ? LetterExtCls : LetterStdCls;
    end
  end

  always_comb begin
    job_o     = '0;
    push_o    = 1'b0;
    pending_d = pending_q;
    if (op_i == OpHeader) begin
      job_o.has_letter = 1'b1;
      job_o.letter     = letter;
      job_o.add_cr     = (sat_len == 7'd0);
      if (is_extended_i) begin
        job_o.nibs  = {3'b000, ident_i, dlc, 4'h0};
        job_o.n_nib = 4'd9;
      end else begin
        job_o.nibs  = {1'b0, ident_i[10:0], dlc, 24'h0};
        job_o.n_nib = 4'd4;
      end
      if (accept) begin
        push_o    = 1'b1;
        pending_d = PendW'(sat_len);
      end
    end else begin
      job_o.nibs   = {data_byte_i, 32'h0};
      job_o.n_nib  = 4'd2;
      job_o.add_cr = (pending_q == PendW'(1));
      // drop a data item when no line is open
      if (accept && pending_q != '0) begin
        push_o    = 1'b1;
        pending_d = pending_q - PendW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else begin
      pending_q <= pending_d;
    end
  end

endmodule

### hw/rtl/c2s_queue.sv
// Short job queue between front and back end; Depth must be a power of two.
// Depends on c2s_pkg.
module c2s_queue #(
  parameter int unsigned Depth = c2s_pkg::QueueDepth
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  c2s_pkg::job_t wdata_i,
  input  logic          pop_i,
  output c2s_pkg::job_t rdata_o,
  output logic          full_o,
  output logic          empty_o
);
  import c2s_pkg::*;

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  job_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            do_push, do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) wr_ptr_q <= wr_ptr_q + PtrW'(1);
      if (do_pop)  rd_ptr_q <= rd_ptr_q + PtrW'(1);
      if (do_push && !do_pop)      count_q <= count_q + CntW'(1);
      else if (do_pop && !do_push) count_q <= count_q - CntW'(1);
    end
  end

endmodule

### hw/rtl/c2s_back.sv
// Back end: serializes queued jobs into ASCII characters via an output register, one per cycle unless stalled.
// Depends on c2s_pkg.
module c2s_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  c2s_pkg::job_t             job_i,
  input  logic                      job_avail_i,
  output logic                      pop_o,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [c2s_pkg::CharW-1:0] ascii_char_o,
  output logic                      end_of_line_o,
  output logic                      last_of_run_o
);
  import c2s_pkg::*;

  logic               busy_q, busy_d;
  logic               let_q, let_d;
  logic [CharW-1:0]   letter_q, letter_d;
  logic [NibW-1:0]    nibs_q, nibs_d;
  logic [NibCntW-1:0] cnt_q, cnt_d;
  logic               cr_q, cr_d;
  logic               ov_q, ov_d;
  logic [CharW-1:0]   ch_q, ch_d;
  logic               eol_q, eol_d;
  logic               last_q, last_d;
  logic               adv, emit, is_last;

  assign adv  = !ov_q || out_ready_i;
  assign emit = adv && busy_q;

  always_comb begin
    busy_d   = busy_q;
    let_d    = let_q;
    letter_d = letter_q;
    nibs_d   = nibs_q;
    cnt_d    = cnt_q;
    cr_d     = cr_q;
    ov_d     = ov_q;
    ch_d     = ch_q;
    eol_d    = eol_q;
    last_d   = last_q;
    is_last  = 1'b0;

    if (let_q) begin
      ch_d    = letter_q;
      eol_d   = 1'b0;
      is_last = (cnt_q == '0) && !cr_q;
    end else if (cnt_q != '0) begin
      ch_d    = hex_char(nibs_q[NibW-1 -: 4]);
      eol_d   = 1'b0;
      is_last = (cnt_q == NibCntW'(1)) && !cr_q;
    end else begin
      ch_d    = AsciiCr;
      eol_d   = 1'b1;
      is_last = 1'b1;
    end
    last_d = is_last;

    if (adv) ov_d = emit;
    if (!emit) begin
      ch_d   = ch_q;
      eol_d  = eol_q;
      last_d = last_q;
    end else begin
      if (let_q) begin
        let_d = 1'b0;
      end else if (cnt_q != '0) begin
        nibs_d = nibs_q << 4;
        cnt_d  = cnt_q - NibCntW'(1);
      end else begin
        cr_d = 1'b0;
      end
      if (is_last) busy_d = 1'b0;
    end

    // load the next job when idle or as the current one finishes
    pop_o = job_avail_i && (!busy_q || (emit && is_last));
    if (pop_o) begin
      busy_d   = 1'b1;
      let_d    = job_i.has_letter;
      letter_d = job_i.letter;
      nibs_d   = job_i.nibs;
      cnt_d    = job_i.n_nib;
      cr_d     = job_i.add_cr;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      ov_q   <= 1'b0;
    end else begin
      busy_q <= busy_d;
      ov_q   <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    let_q    <= let_d;
    letter_q <= letter_d;
    nibs_q   <= nibs_d;
    cnt_q    <= cnt_d;
    cr_q     <= cr_d;
    ch_q     <= ch_d;
    eol_q    <= eol_d;
    last_q   <= last_d;
  end

  assign out_valid_o   = ov_q;
  assign ascii_char_o  = ch_q;
  assign end_of_line_o = eol_q;
  assign last_of_run_o = last_q;

endmodule
